[hw/rtl/tsem_pkg.sv]
// shared types, constants and helper functions for the timestamp-to-epoch core
// no dependencies; every other file in hw/rtl imports this package

package tsem_pkg;

  localparam int unsigned TS_LEN  = 25;
  localparam int unsigned EPOCH_W = 49;

  // what each character position of the layout holds
  typedef enum logic [2:0] {
    FLD_SEP,
    FLD_YEAR,
    FLD_MONTH,
    FLD_DAY,
    FLD_HOUR,
    FLD_MINUTE,
    FLD_SECOND,
    FLD_MILLI
  } field_e;

  // one complete timestamp, as handed from the front end to the back end
  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [9:0]  milli;
    logic        err;
  } ts_rec_t;

  function automatic field_e pos_field(logic [4:0] pos);
    field_e f;
    case (pos)
      5'd0, 5'd1, 5'd2, 5'd3: f = FLD_YEAR;
      5'd5, 5'd6:             f = FLD_MONTH;
      5'd8, 5'd9:             f = FLD_DAY;
      5'd13, 5'd14:           f = FLD_HOUR;
      5'd16, 5'd17:           f = FLD_MINUTE;
      5'd19, 5'd20:           f = FLD_SECOND;
      5'd22, 5'd23, 5'd24:    f = FLD_MILLI;
      default:                f = FLD_SEP;
    endcase
    return f;
  endfunction

  // days before the first of each month in a common year
  function automatic logic [8:0] month_start_days(logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // zero-based month 0..98 split into extra years and month of year
  function automatic logic [7:0] month_split(logic [6:0] mon0);
    logic [3:0] q;
    logic [6:0] r;
    q = 4'd0;
    for (int i = 1; i <= 8; i++) begin
      if (mon0 >= 7'(12 * i)) q = 4'(i);
    end
    r = 7'(mon0 - 7'(q) * 7'd12);
    return {q, r[3:0]};
  endfunction

  // floor(v / 100) by reciprocal, exact for v below 43690
  function automatic logic [7:0] div100(logic [13:0] v);
    logic [27:0] p;
    p = 28'(v) * 28'd10486;
    return p[27:20];
  endfunction

endpackage

[hw/rtl/timestamp_text_to_epoch_ms_core.sv]
// timestamp text to epoch milliseconds: one character per item, one result per 25 items
// throughput: one character per cycle; the 25th stalls only while the record queue is full
// after the 25th character the record passes the record queue, then ten back-end steps to the output slot
// a format error skips the arithmetic: the sequencer goes from idle straight to its done step
// reset (rst_ni, asynchronous, low) clears position, fields, queue and output slot
// built from tsem_front, tsem_fifo and tsem_back; uses tsem_pkg

module timestamp_text_to_epoch_ms_core import tsem_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                char_code_i,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [EPOCH_W-1:0] epoch_ms_o,
  output logic                      format_error_o
);

  ts_rec_t front_rec, back_rec;
  logic    rec_push, q_full, q_empty, rec_pop;

  tsem_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .char_code_i (char_code_i),
    .q_full_i    (q_full),
    .rec_push_o  (rec_push),
    .rec_o       (front_rec)
  );

  tsem_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .data_i  (front_rec),
    .full_o  (q_full),
    .pop_i   (rec_pop),
    .data_o  (back_rec),
    .empty_o (q_empty)
  );

  tsem_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rec_i          (back_rec),
    .rec_empty_i    (q_empty),
    .rec_pop_o      (rec_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .epoch_ms_o     (epoch_ms_o),
    .format_error_o (format_error_o)
  );

endmodule

[hw/rtl/tsem_front.sv]
// front end: takes one character per item, builds the decimal fields by position
// and hands each finished timestamp to the queue; uses tsem_pkg

module tsem_front import tsem_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] char_code_i,
  input  logic       q_full_i,
  output logic       rec_push_o,
  output ts_rec_t    rec_o
);

  logic [4:0]  pos_q;
  logic [13:0] year_q, year_d;
  logic [6:0]  month_q, month_d;
  logic [6:0]  day_q, day_d;
  logic [6:0]  hour_q, hour_d;
  logic [6:0]  minute_q, minute_d;
  logic [6:0]  second_q, second_d;
  logic [9:0]  milli_q, milli_d;
  logic        bad_q, bad_d;

  logic        accept;
  logic        last;
  logic        is_digit;
  logic [3:0]  digit;
  field_e      field;

  assign last     = (pos_q == 5'(TS_LEN - 1));
  assign full_o   = last & q_full_i;
  assign accept   = push_i & ~full_o;
  assign field    = pos_field(pos_q);
  assign is_digit = (char_code_i >= 8'h30) && (char_code_i <= 8'h39);
  assign digit    = 4'(char_code_i - 8'h30);

  always_comb begin
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    milli_d  = milli_q;
    bad_d    = bad_q;
    if (field != FLD_SEP) begin
      if (is_digit) begin
        case (field)
          FLD_YEAR:   year_d   = 14'(year_q * 14'd10 + 14'(digit));
          FLD_MONTH:  month_d  = 7'(month_q * 7'd10 + 7'(digit));
          FLD_DAY:    day_d    = 7'(day_q * 7'd10 + 7'(digit));
          FLD_HOUR:   hour_d   = 7'(hour_q * 7'd10 + 7'(digit));
          FLD_MINUTE: minute_d = 7'(minute_q * 7'd10 + 7'(digit));
          FLD_SECOND: second_d = 7'(second_q * 7'd10 + 7'(digit));
          FLD_MILLI:  milli_d  = 10'(milli_q * 10'd10 + 10'(digit));
          default:    bad_d    = bad_q;
        endcase
      end else begin
        bad_d = 1'b1;
      end
    end
  end

  // record built from the updated fields so the last character is included
  always_comb begin
    rec_o.year   = year_d;
    rec_o.month  = month_d;
    rec_o.day    = day_d;
    rec_o.hour   = hour_d;
    rec_o.minute = minute_d;
    rec_o.second = second_d;
    rec_o.milli  = milli_d;
    rec_o.err    = bad_d | (month_d == 7'd0);
  end

  assign rec_push_o = accept & last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      milli_q  <= '0;
      bad_q    <= 1'b0;
    end else if (accept) begin
      if (last) begin
        pos_q    <= '0;
        year_q   <= '0;
        month_q  <= '0;
        day_q    <= '0;
        hour_q   <= '0;
        minute_q <= '0;
        second_q <= '0;
        milli_q  <= '0;
        bad_q    <= 1'b0;
      end else begin
        pos_q    <= 5'(pos_q + 5'd1);
        year_q   <= year_d;
        month_q  <= month_d;
        day_q    <= day_d;
        hour_q   <= hour_d;
        minute_q <= minute_d;
        second_q <= second_d;
        milli_q  <= milli_d;
        bad_q    <= bad_d;
      end
    end
  end

endmodule

[hw/rtl/tsem_fifo.sv]
// short queue of finished timestamps between the front end and the back end
// uses tsem_pkg for the record type

module tsem_fifo import tsem_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  ts_rec_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output ts_rec_t data_o,
  output logic    empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ts_rec_t       mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_q <= CW'(count_q + 1'b1);
      end else if (do_pop && !do_push) begin
        count_q <= CW'(count_q - 1'b1);
      end
    end
  end

  // the front end holds its last character while the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("timestamp pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

[hw/rtl/tsem_back.sv]
// back end: sequencer that turns one timestamp record into epoch milliseconds
// over ten steps with one shared divide-by-100 unit; uses tsem_pkg

module tsem_back import tsem_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ts_rec_t                   rec_i,
  input  logic                      rec_empty_i,
  output logic                      rec_pop_o,
  input  logic                      pop_i,
  output logic                      empty_o,
  output logic signed [EPOCH_W-1:0] epoch_ms_o,
  output logic                      format_error_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_BASE  = 4'd1;
  localparam logic [3:0] ST_C100  = 4'd2;
  localparam logic [3:0] ST_C400  = 4'd3;
  localparam logic [3:0] ST_LEAPQ = 4'd4;
  localparam logic [3:0] ST_LEAP  = 4'd5;
  localparam logic [3:0] ST_HOUR  = 4'd6;
  localparam logic [3:0] ST_MIN   = 4'd7;
  localparam logic [3:0] ST_SEC   = 4'd8;
  localparam logic [3:0] ST_MS    = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  logic [3:0]  state_q, state_d;
  logic [13:0] year_q;
  logic [3:0]  mon_q;
  logic [6:0]  day_q, hour_q, minute_q, second_q;
  logic [9:0]  milli_q;
  logic        err_q;
  logic [7:0]  lq_q, lq_d;
  logic signed [EPOCH_W-1:0] acc_q, acc_d;

  logic                      res_valid_q;
  logic signed [EPOCH_W-1:0] res_ms_q;
  logic                      res_err_q;
  logic                      out_pop, res_load;

  logic        start;
  logic [7:0]  msplit;
  logic [6:0]  mon0;

  logic signed [14:0] d70, d68, d00, d1600;
  logic [13:0] abs68, abs00, abs1600;
  logic [13:0] div_in;
  logic [7:0]  div_res;
  logic signed [EPOCH_W-1:0] q_ext;
  logic signed [24:0] t4, base;
  logic        cent, leap;

  assign start     = (state_q == ST_IDLE) && !rec_empty_i;
  assign rec_pop_o = start;
  assign mon0      = 7'(rec_i.month - 7'd1);
  assign msplit    = month_split(mon0);

  assign d70   = $signed({1'b0, year_q}) - 15'sd1970;
  assign d68   = $signed({1'b0, year_q}) - 15'sd1968;
  assign d00   = $signed({1'b0, year_q}) - 15'sd1900;
  assign d1600 = $signed({1'b0, year_q}) - 15'sd1600;
  assign abs68   = d68[14]   ? 14'(-d68)   : d68[13:0];
  assign abs00   = d00[14]   ? 14'(-d00)   : d00[13:0];
  assign abs1600 = d1600[14] ? 14'(-d1600) : d1600[13:0];

  // shared reciprocal divider, operand picked by the step
  always_comb begin
    case (state_q)
      ST_C100: div_in = abs00;
      ST_C400: div_in = {2'b00, abs1600[13:2]};
      default: div_in = year_q;
    endcase
  end
  assign div_res = div100(div_in);
  assign q_ext   = $signed({{(EPOCH_W-8){1'b0}}, div_res});

  // truncating division by four of year - 1968
  assign t4   = d68[14] ? -$signed({13'b0, abs68[13:2]}) : $signed({13'b0, abs68[13:2]});
  assign base = 25'(d70) * 25'sd365 + $signed({16'b0, month_start_days(mon_q)})
              + $signed({18'b0, day_q}) - 25'sd1 + t4;

  assign cent = (year_q == 14'(lq_q * 14'd100));
  assign leap = (year_q[1:0] == 2'b00) && (!cent || (lq_q[1:0] == 2'b00));

  assign out_pop  = pop_i & res_valid_q;
  assign res_load = (state_q == ST_DONE) && (!res_valid_q || out_pop);

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    lq_d    = lq_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          acc_d   = '0;
          state_d = rec_i.err ? ST_DONE : ST_BASE;
        end
      end
      ST_BASE: begin
        acc_d   = EPOCH_W'(base);
        state_d = ST_C100;
      end
      ST_C100: begin
        acc_d   = d00[14] ? acc_q + q_ext : acc_q - q_ext;
        state_d = ST_C400;
      end
      ST_C400: begin
        acc_d   = d1600[14] ? acc_q - q_ext : acc_q + q_ext;
        state_d = ST_LEAPQ;
      end
      ST_LEAPQ: begin
        lq_d    = div_res;
        state_d = ST_LEAP;
      end
      ST_LEAP: begin
        if (leap && (mon_q < 4'd2)) acc_d = acc_q - 49'sd1;
        state_d = ST_HOUR;
      end
      ST_HOUR: begin
        acc_d   = acc_q * 49'sd24 + $signed({42'b0, hour_q});
        state_d = ST_MIN;
      end
      ST_MIN: begin
        acc_d   = acc_q * 49'sd60 + $signed({42'b0, minute_q});
        state_d = ST_SEC;
      end
      ST_SEC: begin
        acc_d   = acc_q * 49'sd60 + $signed({42'b0, second_q});
        state_d = ST_MS;
      end
      ST_MS: begin
        acc_d   = acc_q * 49'sd1000 + $signed({39'b0, milli_q});
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_load) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    lq_q  <= lq_d;
    if (start) begin
      year_q   <= 14'(rec_i.year + 14'(msplit[7:4]));
      mon_q    <= msplit[3:0];
      day_q    <= rec_i.day;
      hour_q   <= rec_i.hour;
      minute_q <= rec_i.minute;
      second_q <= rec_i.second;
      milli_q  <= rec_i.milli;
      err_q    <= rec_i.err;
    end
    if (res_load) begin
      res_ms_q  <= acc_q;
      res_err_q <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (out_pop) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o        = ~res_valid_q;
  assign epoch_ms_o     = res_ms_q;
  assign format_error_o = res_err_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_err_q) |-> (res_ms_q == '0))
    else $error("error result with non-zero epoch");

  // a finished conversion waits while the output slot is still occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && res_valid_q && !pop_i) |=> (state_q == ST_DONE))
    else $error("conversion left done state over an untaken result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_pop_o && rec_i.err) |=> ((state_q == ST_DONE) && err_q && (acc_q == '0)))
    else $error("bad timestamp did not take the error path");

endmodule
